// File: src/atma_pkg.sv
// Shared types, constants, the arctangent lookup and the output rounding function for the accelerometer tilt block.
// Depends on nothing; imported by accel_tilt_moving_average_top.
`default_nettype none

package atma_pkg;

    localparam int DEF_WINDOW       = 10;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam int ROLL_W    = 16;
    localparam int PITCH_W   = 15;
    localparam int ANG_W     = 20;
    localparam int FRAC      = 16;
    localparam int GAIN_W    = 16;
    localparam int TAB_IDX_W = 5;
    localparam int OUT_SHIFT = 3;

    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic [TAB_IDX_W-1:0]    tab_idx_t;

    localparam ang_t HALF_PI     = 20'sd102944;
    localparam ang_t ROLL_LIMIT  = 20'sd25736;
    localparam ang_t PITCH_LIMIT = 20'sd12868;
    localparam ang_t ANG_RND     = 20'sd4;

    localparam logic [GAIN_W-1:0] INV_GAIN = 16'd39797;

    function automatic ang_t atan_unit(input tab_idx_t idx);
        ang_t val;
        case (idx)
            5'd0:    val = 20'sd51472;
            5'd1:    val = 20'sd30386;
            5'd2:    val = 20'sd16055;
            5'd3:    val = 20'sd8150;
            5'd4:    val = 20'sd4091;
            5'd5:    val = 20'sd2047;
            5'd6:    val = 20'sd1024;
            5'd7:    val = 20'sd512;
            5'd8:    val = 20'sd256;
            5'd9:    val = 20'sd128;
            5'd10:   val = 20'sd64;
            5'd11:   val = 20'sd32;
            5'd12:   val = 20'sd16;
            5'd13:   val = 20'sd8;
            5'd14:   val = 20'sd4;
            5'd15:   val = 20'sd2;
            5'd16:   val = 20'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

    function automatic ang_t round_sat(input ang_t acc, input ang_t lim);
        ang_t val;
        val = (acc + ANG_RND) >>> OUT_SHIFT;
        if (val > lim) begin
            val = lim;
        end else if (val < -lim) begin
            val = -lim;
        end
        return val;
    endfunction

endpackage

`default_nettype wire

// File: src/accel_tilt_moving_average_top.sv
// Tilt sensor top level: sample ring, running sums and a bit-serial CORDIC engine.
// Depends on atma_pkg (constants, arctangent table, output rounding).
//
// Usage:
//   Input channel s_valid/s_ready carries one beat per three-axis sample
//   (s_accel_x/y/z, SAMPLE_BITS signed each). Result channel m_valid/m_ready
//   carries one beat per sample: m_roll_angle (signed Q2.13) and
//   m_pitch_angle (signed Q1.13), both in radians.
//   Each sample enters a ring of the last WINDOW samples; per-axis running
//   sums feed two CORDIC vectoring passes (roll from y/z, then pitch from x
//   against the gain-compensated y/z magnitude).
//   The CORDIC datapath is bit-serial: one bit of both operands per cycle,
//   with operands W = SAMPLE_BITS + clog2(WINDOW) + 19 bits wide.
//   One sample is processed at a time; s_ready rises again together with
//   the result entering the output register, so the next sample is only
//   accepted once the previous result has left the engine.
//   A result waiting in the output register does not block the next
//   sample; if the receiver still stalls when the next result is done,
//   the engine holds until the output register frees.
//   Reset (aresetn low, synchronous) invalidates the ring and clears the sums,
//   the write position and any pending result; no clearing pass is needed.
`default_nettype none

module accel_tilt_moving_average_top
    import atma_pkg::*;
#(
    parameter int WINDOW       = DEF_WINDOW,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire signed [SAMPLE_BITS-1:0]  s_accel_x,
    input  wire signed [SAMPLE_BITS-1:0]  s_accel_y,
    input  wire signed [SAMPLE_BITS-1:0]  s_accel_z,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic signed [ROLL_W-1:0]      m_roll_angle,
    output logic signed [PITCH_W-1:0]     m_pitch_angle
);

    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int W      = SUM_W + 19;
    localparam int HI_W   = W - FRAC;
    localparam int KW     = $clog2(W);
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int LO_W   = FRAC + GAIN_W;
    localparam int RING_W = 3 * SAMPLE_BITS;

    localparam logic [LO_W-1:0] LO_RND = LO_W'(1) << (FRAC - 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UPD     = 3'd1;
    localparam logic [2:0] S_LOAD    = 3'd2;
    localparam logic [2:0] S_ROT     = 3'd3;
    localparam logic [2:0] S_COMP_LO = 3'd4;
    localparam logic [2:0] S_COMP_HI = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    logic [2:0]                    state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] smp_x_reg, smp_y_reg, smp_z_reg;
    logic [RING_W-1:0]             ring_mem [WINDOW];
    logic [RING_W-1:0]             ring_rd_reg;
    logic [WINDOW-1:0]             ring_vld_reg;
    logic [POS_W-1:0]              pos_reg;
    logic signed [SUM_W-1:0]       sum_x_reg, sum_y_reg, sum_z_reg;
    logic [W-1:0]                  a_reg, b_reg;
    ang_t                          acc_reg, roll_acc_reg;
    logic [KW-1:0]                 bit_reg;
    logic [STEP_W-1:0]             step_reg;
    logic                          pass_reg;
    logic                          roll_zero_reg, zero_reg;
    logic                          sa_reg, sb_reg, ca_reg, cb_reg;
    logic [GAIN_W-1:0]             comp_lo_reg;
    logic                          m_valid_reg;
    logic signed [ROLL_W-1:0]      m_roll_reg;
    logic signed [PITCH_W-1:0]     m_pitch_reg;

    logic                          old_vld;
    logic signed [SAMPLE_BITS-1:0] old_x, old_y, old_z;
    logic signed [SUM_W:0]         ry, rz, ld_a, ld_b;
    ang_t                          ld_acc;
    logic [KW:0]                   reach;
    logic                          in_rng, rot_first, rot_last_bit, rot_last_step;
    logic                          sa_now, sb_now, pos_dir;
    logic                          ta, tb, ta_op, tb_op, ca_in, cb_in;
    logic                          a_bit, b_bit, ca_out, cb_out;
    logic [LO_W-1:0]               lo_prod;
    logic [W-1:0]                  hi_prod, comp;
    logic                          mag_pos;
    logic                          out_free;
    ang_t                          pitch_acc;

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_roll_angle  = m_roll_reg;
    assign m_pitch_angle = m_pitch_reg;
    assign out_free      = !m_valid_reg || m_ready;

    // ring storage and registered read at the write position
    always_ff @(posedge aclk) begin
        if (state_reg == S_UPD) begin
            ring_mem[pos_reg] <= {smp_x_reg, smp_y_reg, smp_z_reg};
        end
        ring_rd_reg <= ring_mem[pos_reg];
    end

    always_comb begin
        old_vld = ring_vld_reg[pos_reg];
        old_x   = old_vld ? ring_rd_reg[RING_W-1 -: SAMPLE_BITS] : '0;
        old_y   = old_vld ? ring_rd_reg[2*SAMPLE_BITS-1 -: SAMPLE_BITS] : '0;
        old_z   = old_vld ? ring_rd_reg[SAMPLE_BITS-1:0] : '0;
    end

    // roll operands with the quadrant pre-rotation
    always_comb begin
        ry     = (SUM_W+1)'(sum_y_reg);
        rz     = (SUM_W+1)'(sum_z_reg);
        ld_a   = rz;
        ld_b   = ry;
        ld_acc = '0;
        if (rz[SUM_W]) begin
            if (!ry[SUM_W]) begin
                ld_a   = ry;
                ld_b   = -rz;
                ld_acc = HALF_PI;
            end else begin
                ld_a   = -ry;
                ld_b   = rz;
                ld_acc = -HALF_PI;
            end
        end
    end

    // bit-serial micro-rotation: both operands stream LSB first
    always_comb begin
        rot_first     = (bit_reg == '0);
        rot_last_bit  = (bit_reg == KW'(W - 1));
        rot_last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));
        reach         = {1'b0, bit_reg} + (KW+1)'(step_reg);
        in_rng        = reach < (KW+1)'(W);
        sa_now        = rot_first ? a_reg[W-1] : sa_reg;
        sb_now        = rot_first ? b_reg[W-1] : sb_reg;
        pos_dir       = !sb_now;
        ta            = in_rng ? b_reg[KW'(step_reg)] : sb_now;
        tb            = in_rng ? a_reg[KW'(step_reg)] : sa_now;
        ta_op         = pos_dir ? ta : !ta;
        tb_op         = pos_dir ? !tb : tb;
        ca_in         = rot_first ? !pos_dir : ca_reg;
        cb_in         = rot_first ? pos_dir : cb_reg;
        a_bit         = a_reg[0] ^ ta_op ^ ca_in;
        b_bit         = b_reg[0] ^ tb_op ^ cb_in;
        ca_out        = (a_reg[0] & ta_op) | (a_reg[0] & ca_in) | (ta_op & ca_in);
        cb_out        = (b_reg[0] & tb_op) | (b_reg[0] & cb_in) | (tb_op & cb_in);
    end

    // gain compensation of the roll magnitude, split over the S_COMP_LO and S_COMP_HI states
    always_comb begin
        lo_prod   = LO_W'(a_reg[FRAC-1:0]) * LO_W'(INV_GAIN) + LO_RND;
        hi_prod   = W'(a_reg[W-1:FRAC]) * W'(INV_GAIN);
        mag_pos   = !roll_zero_reg && !a_reg[W-1] && (a_reg != '0);
        comp      = mag_pos ? (hi_prod + W'(comp_lo_reg)) : '0;
        pitch_acc = zero_reg ? '0 : acc_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_UPD;
                end
            end
            S_UPD:     state_next = S_LOAD;
            S_LOAD:    state_next = S_ROT;
            S_ROT: begin
                if (rot_last_bit && rot_last_step) begin
                    state_next = pass_reg ? S_OUT : S_COMP_LO;
                end
            end
            S_COMP_LO: state_next = S_COMP_HI;
            S_COMP_HI: state_next = S_ROT;
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ring_vld_reg <= '0;
            pos_reg      <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            sum_z_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_UPD: begin
                    sum_x_reg <= sum_x_reg + SUM_W'(smp_x_reg) - SUM_W'(old_x);
                    sum_y_reg <= sum_y_reg + SUM_W'(smp_y_reg) - SUM_W'(old_y);
                    sum_z_reg <= sum_z_reg + SUM_W'(smp_z_reg) - SUM_W'(old_z);
                    ring_vld_reg[pos_reg] <= 1'b1;
                    if (pos_reg == POS_W'(WINDOW - 1)) begin
                        pos_reg <= '0;
                    end else begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    smp_x_reg <= s_accel_x;
                    smp_y_reg <= s_accel_y;
                    smp_z_reg <= s_accel_z;
                end
            end
            S_LOAD: begin
                a_reg         <= {HI_W'(ld_a), {FRAC{1'b0}}};
                b_reg         <= {HI_W'(ld_b), {FRAC{1'b0}}};
                acc_reg       <= ld_acc;
                roll_zero_reg <= (sum_y_reg == '0) && (sum_z_reg == '0);
                pass_reg      <= 1'b0;
                bit_reg       <= '0;
                step_reg      <= '0;
            end
            S_ROT: begin
                a_reg  <= {a_bit, a_reg[W-1:1]};
                b_reg  <= {b_bit, b_reg[W-1:1]};
                sa_reg <= sa_now;
                sb_reg <= sb_now;
                ca_reg <= ca_out;
                cb_reg <= cb_out;
                if (rot_first) begin
                    if (pos_dir) begin
                        acc_reg <= acc_reg + atan_unit(TAB_IDX_W'(step_reg));
                    end else begin
                        acc_reg <= acc_reg - atan_unit(TAB_IDX_W'(step_reg));
                    end
                end
                if (rot_last_bit) begin
                    bit_reg <= '0;
                    if (rot_last_step) begin
                        step_reg <= '0;
                        if (!pass_reg) begin
                            roll_acc_reg <= roll_zero_reg ? '0 : acc_reg;
                        end
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end else begin
                    bit_reg <= bit_reg + 1'b1;
                end
            end
            S_COMP_LO: begin
                comp_lo_reg <= lo_prod[LO_W-1:FRAC];
            end
            S_COMP_HI: begin
                a_reg    <= comp;
                b_reg    <= {HI_W'(sum_x_reg), {FRAC{1'b0}}};
                acc_reg  <= '0;
                zero_reg <= (comp == '0) && (sum_x_reg == '0);
                pass_reg <= 1'b1;
                bit_reg  <= '0;
                step_reg <= '0;
            end
            S_OUT: begin
                if (out_free) begin
                    m_roll_reg  <= ROLL_W'(round_sat(roll_acc_reg, ROLL_LIMIT));
                    m_pitch_reg <= PITCH_W'(round_sat(pitch_acc, PITCH_LIMIT));
                end
            end
            default: begin
            end
        endcase
    end

    a_accept_starts_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_UPD))
        else $error("accepted beat did not start the sum update");

    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROT) |-> (bit_reg <= KW'(W - 1)))
        else $error("bit counter beyond operand width");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(WINDOW - 1))
        else $error("ring write position beyond window");

    a_roll_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((ANG_W'(m_roll_reg) <= ROLL_LIMIT)
                         && (ANG_W'(m_roll_reg) >= -ROLL_LIMIT)))
        else $error("roll result outside its range");

    a_result_after_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside the output state");

endmodule

`default_nettype wire
